// ===== rtl/core/i2cm_pkg.sv =====
// Package with the item types, command codes and step constants of the I2C master byte engine.
`timescale 1ns / 1ps
`default_nettype none
package i2cm_pkg;

  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_START = 3'd1;
  localparam logic [2:0] ACT_STOP  = 3'd2;
  localparam logic [2:0] ACT_WRITE = 3'd3;
  localparam logic [2:0] ACT_READ  = 3'd4;

  localparam int unsigned STEP_W = 5;

  localparam logic [STEP_W-1:0] STEP_FIRST    = 5'd0;
  localparam logic [STEP_W-1:0] STEP_ONE      = 5'd1;
  localparam logic [STEP_W-1:0] STEP_TWO      = 5'd2;
  localparam logic [STEP_W-1:0] STEP_BITS_END = 5'd16;
  localparam logic [STEP_W-1:0] STEP_ACK_SET  = 5'd17;
  localparam logic [STEP_W-1:0] STEP_ACK_HIGH = 5'd18;

  typedef enum logic [2:0] {
    CMD_IDLE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4
  } cmd_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] tx_byte;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       no_ack;
  } out_item_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] tx_byte;
    logic       sda_in;
  } tick_t;

endpackage
`default_nettype wire

// ===== rtl/core/i2cm_front.sv =====
// Front end that accepts input items and decodes the action into a command for the queue.
`timescale 1ns / 1ps
`default_nettype none
module i2cm_front (
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire i2cm_pkg::in_item_t in_item,
  input  wire logic               q_full,
  output logic                    push,
  output i2cm_pkg::tick_t         push_tick
);
  import i2cm_pkg::*;

  cmd_t cmd;

  always_comb begin
    case (in_item.action)
      ACT_START: cmd = CMD_START;
      ACT_STOP:  cmd = CMD_STOP;
      ACT_WRITE: cmd = CMD_WRITE;
      ACT_READ:  cmd = CMD_READ;
      default:   cmd = CMD_IDLE;
    endcase
  end

  assign in_ready          = !q_full;
  assign push              = in_valid && !q_full;
  assign push_tick.cmd     = cmd;
  assign push_tick.tx_byte = in_item.tx_byte;
  assign push_tick.sda_in  = in_item.sda_in;

endmodule
`default_nettype wire

// ===== rtl/core/i2cm_queue.sv =====
// Two-entry queue of decoded ticks between the front end and the bus sequencer.
`timescale 1ns / 1ps
`default_nettype none
module i2cm_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire i2cm_pkg::tick_t push_tick,
  output logic                 full,
  output logic                 q_valid,
  input  wire logic            pop,
  output i2cm_pkg::tick_t      head
);
  import i2cm_pkg::*;

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = 1;
  localparam int unsigned CNT_W = 2;

  tick_t            mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign q_valid = (cnt_r != '0);
  assign head    = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_tick;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/i2cm_back.sv =====
// Bus sequencer that runs one step per tick and holds the result in an output register.
`timescale 1ns / 1ps
`default_nettype none
module i2cm_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_valid,
  input  wire i2cm_pkg::tick_t head,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output i2cm_pkg::out_item_t  out_item
);
  import i2cm_pkg::*;

  cmd_t              cmd_r, cmd_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [7:0]        shift_r, shift_nxt;
  logic [7:0]        rx_r, rx_nxt;
  logic              miss_r, miss_nxt;
  logic              scl_r, scl_nxt;
  logic              sda_r, sda_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r, out_item_nxt;
  logic              done;

  assign pop       = q_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    cmd_nxt   = cmd_r;
    step_nxt  = step_r;
    shift_nxt = shift_r;
    rx_nxt    = rx_r;
    miss_nxt  = miss_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    done      = 1'b0;

    if (cmd_r == CMD_IDLE && head.cmd != CMD_IDLE) begin
      cmd_nxt  = head.cmd;
      step_nxt = STEP_FIRST;
      if (head.cmd == CMD_START) begin
        miss_nxt = 1'b0;
      end
      if (head.cmd == CMD_WRITE) begin
        shift_nxt = head.tx_byte;
      end
    end

    case (cmd_nxt)
      CMD_START: begin
        if (step_nxt == STEP_FIRST) begin
          scl_nxt = 1'b1;
          sda_nxt = 1'b1;
        end else if (step_nxt == STEP_ONE) begin
          sda_nxt = 1'b0;
        end else begin
          scl_nxt = 1'b0;
          done    = 1'b1;
        end
      end
      CMD_STOP: begin
        if (step_nxt == STEP_FIRST) begin
          scl_nxt = 1'b0;
        end else if (step_nxt == STEP_ONE) begin
          sda_nxt = 1'b0;
        end else if (step_nxt == STEP_TWO) begin
          scl_nxt = 1'b1;
        end else begin
          sda_nxt = 1'b1;
          done    = 1'b1;
        end
      end
      CMD_WRITE: begin
        if (step_nxt == STEP_FIRST) begin
          scl_nxt = 1'b0;
        end else if (step_nxt <= STEP_BITS_END) begin
          if (step_nxt[0]) begin
            scl_nxt = 1'b0;
            sda_nxt = shift_nxt[7];
          end else begin
            scl_nxt   = 1'b1;
            shift_nxt = {shift_nxt[6:0], 1'b0};
          end
        end else if (step_nxt == STEP_ACK_SET) begin
          scl_nxt = 1'b0;
          sda_nxt = 1'b1;
        end else if (step_nxt == STEP_ACK_HIGH) begin
          scl_nxt = 1'b1;
          if (head.sda_in) begin
            miss_nxt = 1'b1;
          end
        end else begin
          scl_nxt = 1'b0;
          done    = 1'b1;
        end
      end
      CMD_READ: begin
        if (step_nxt == STEP_FIRST) begin
          scl_nxt   = 1'b0;
          sda_nxt   = 1'b1;
          shift_nxt = '0;
        end else if (step_nxt <= STEP_BITS_END) begin
          if (step_nxt[0]) begin
            scl_nxt   = 1'b1;
            shift_nxt = {shift_nxt[6:0], head.sda_in};
          end else begin
            scl_nxt = 1'b0;
            if (step_nxt == STEP_BITS_END) begin
              rx_nxt = shift_nxt;
            end
          end
        end else if (step_nxt == STEP_ACK_SET) begin
          scl_nxt = 1'b1;
          sda_nxt = 1'b1;
        end else begin
          scl_nxt = 1'b0;
          done    = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (cmd_nxt != CMD_IDLE) begin
      if (done) begin
        cmd_nxt  = CMD_IDLE;
        step_nxt = STEP_FIRST;
      end else begin
        step_nxt = step_nxt + 1'b1;
      end
    end

    out_item_nxt.scl_level = scl_nxt;
    out_item_nxt.sda_level = sda_nxt;
    out_item_nxt.busy_res  = (cmd_nxt != CMD_IDLE);
    out_item_nxt.done_res  = done;
    out_item_nxt.rx_byte   = rx_nxt;
    out_item_nxt.no_ack    = miss_nxt;

    out_valid_nxt = pop || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_item_r <= out_item_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r       <= CMD_IDLE;
      step_r      <= '0;
      shift_r     <= '0;
      rx_r        <= '0;
      miss_r      <= 1'b0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        cmd_r   <= cmd_nxt;
        step_r  <= step_nxt;
        shift_r <= shift_nxt;
        rx_r    <= rx_nxt;
        miss_r  <= miss_nxt;
        scl_r   <= scl_nxt;
        sda_r   <= sda_nxt;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/i2c_master_byte_engine.sv =====
// Top level of the tick-driven I2C master byte engine.
// Each accepted item yields one result item, registered first in the queue entry and then in the output register.
// Throughput is one item per cycle while out_ready stays high; the sequencer runs one bus step per item.
// A two-entry queue separates the decoder from the sequencer and absorbs stalls.
// Synchronous active-low reset idles the engine with SCL and SDA released high.
`timescale 1ns / 1ps
`default_nettype none
module i2c_master_byte_engine (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire i2cm_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output i2cm_pkg::out_item_t      out_item
);
  import i2cm_pkg::*;

  logic  q_full;
  logic  push;
  tick_t push_tick;
  logic  q_valid;
  logic  pop;
  tick_t head;

  i2cm_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .q_full    (q_full),
    .push      (push),
    .push_tick (push_tick)
  );

  i2cm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_tick (push_tick),
    .full      (q_full),
    .q_valid   (q_valid),
    .pop       (pop),
    .head      (head)
  );

  i2cm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

// ===== sim/i2c_master_byte_engine_tb.sv =====
// Testbench that drives bus ticks through the I2C master byte engine and checks every result item.
`timescale 1ns / 1ps
module i2c_master_byte_engine_tb;
  import i2cm_pkg::*;

  localparam int TICK_TARGET = 1750;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 50;

  class bus_tick_scoreboard;
    cmd_t       active_cmd;
    logic [4:0] step;
    logic [7:0] shreg;
    logic [7:0] rx_hold;
    logic       nack_flag;
    logic       scl_q;
    logic       sda_q;
    out_item_t  pending_levels[$];
    int         mismatches;
    int         checked;
    int         taken[8];

    function new();
      active_cmd = CMD_IDLE;
      step = STEP_FIRST;
      shreg = 8'h00;
      rx_hold = 8'h00;
      nack_flag = 1'b0;
      scl_q = 1'b1;
      sda_q = 1'b1;
      mismatches = 0;
      checked = 0;
      for (int i = 0; i < 8; i++) taken[i] = 0;
    endfunction

    function void note_tick(in_item_t it);
      out_item_t r;
      logic      fin;
      fin = 1'b0;
      if (active_cmd == CMD_IDLE && it.action >= ACT_START && it.action <= ACT_READ) begin
        active_cmd = cmd_t'(it.action);
        step = STEP_FIRST;
        taken[it.action]++;
        if (it.action == ACT_START) nack_flag = 1'b0;
        if (it.action == ACT_WRITE) shreg = it.tx_byte;
      end
      if (active_cmd != CMD_IDLE) begin
        case (active_cmd)
          CMD_START: begin
            if (step == STEP_FIRST) begin
              scl_q = 1'b1;
              sda_q = 1'b1;
            end else if (step == STEP_ONE) begin
              sda_q = 1'b0;
            end else begin
              scl_q = 1'b0;
              fin = 1'b1;
            end
          end
          CMD_STOP: begin
            if (step == STEP_FIRST) begin
              scl_q = 1'b0;
            end else if (step == STEP_ONE) begin
              sda_q = 1'b0;
            end else if (step == STEP_TWO) begin
              scl_q = 1'b1;
            end else begin
              sda_q = 1'b1;
              fin = 1'b1;
            end
          end
          CMD_WRITE: begin
            if (step == STEP_FIRST) begin
              scl_q = 1'b0;
            end else if (step <= STEP_BITS_END) begin
              if (step[0]) begin
                scl_q = 1'b0;
                sda_q = shreg[7];
              end else begin
                scl_q = 1'b1;
                shreg = {shreg[6:0], 1'b0};
              end
            end else if (step == STEP_ACK_SET) begin
              scl_q = 1'b0;
              sda_q = 1'b1;
            end else if (step == STEP_ACK_HIGH) begin
              scl_q = 1'b1;
              if (it.sda_in) nack_flag = 1'b1;
            end else begin
              scl_q = 1'b0;
              fin = 1'b1;
            end
          end
          CMD_READ: begin
            if (step == STEP_FIRST) begin
              scl_q = 1'b0;
              sda_q = 1'b1;
              shreg = 8'h00;
            end else if (step <= STEP_BITS_END) begin
              if (step[0]) begin
                scl_q = 1'b1;
                shreg = {shreg[6:0], it.sda_in};
              end else begin
                scl_q = 1'b0;
                if (step == STEP_BITS_END) rx_hold = shreg;
              end
            end else if (step == STEP_ACK_SET) begin
              scl_q = 1'b1;
              sda_q = 1'b1;
            end else begin
              scl_q = 1'b0;
              fin = 1'b1;
            end
          end
          default: fin = 1'b1;
        endcase
        if (fin) begin
          active_cmd = CMD_IDLE;
          step = STEP_FIRST;
        end else begin
          step = step + 5'd1;
        end
      end
      r.scl_level = scl_q;
      r.sda_level = sda_q;
      r.busy_res = (active_cmd != CMD_IDLE);
      r.done_res = fin;
      r.rx_byte = rx_hold;
      r.no_ack = nack_flag;
      pending_levels.push_back(r);
    endfunction

    function void check_levels(out_item_t got);
      out_item_t want;
      if (pending_levels.size() == 0) begin
        $error("result item %h arrived with no expectation waiting", got);
        mismatches++;
        return;
      end
      want = pending_levels.pop_front();
      checked++;
      if (got.scl_level !== want.scl_level) begin
        $error("scl_level: expected %0d, got %0d", want.scl_level, got.scl_level);
        mismatches++;
      end
      if (got.sda_level !== want.sda_level) begin
        $error("sda_level: expected %0d, got %0d", want.sda_level, got.sda_level);
        mismatches++;
      end
      if (got.busy_res !== want.busy_res) begin
        $error("busy_res: expected %0d, got %0d", want.busy_res, got.busy_res);
        mismatches++;
      end
      if (got.done_res !== want.done_res) begin
        $error("done_res: expected %0d, got %0d", want.done_res, got.done_res);
        mismatches++;
      end
      if (got.rx_byte !== want.rx_byte) begin
        $error("rx_byte: expected %0h, got %0h", want.rx_byte, got.rx_byte);
        mismatches++;
      end
      if (got.no_ack !== want.no_ack) begin
        $error("no_ack: expected %0d, got %0d", want.no_ack, got.no_ack);
        mismatches++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  bus_tick_scoreboard sb;
  int snd_idle = 0;
  int rcv_idle = 0;
  int ticks_sent = 0;
  int cycle_count = 0;

  i2c_master_byte_engine dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[i2c_master_byte_engine] ERROR");
      $finish;
    end
  end

  initial begin
    wait (rst_n === 1'b1);
    forever begin
      out_ready <= ($urandom_range(0, 99) >= rcv_idle);
      @(posedge clk);
      if (out_valid && out_ready) sb.check_levels(out_item);
    end
  end

  task automatic send_tick(in_item_t it);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_tick(it);
    ticks_sent++;
  endtask

  // One command from an idle engine, followed by the ticks that finish it.
  task automatic run_command(logic [2:0] act, logic [7:0] tx, logic [7:0] rd_byte,
                             logic ack_bit, bit noise);
    in_item_t t;
    int       len;
    case (act)
      ACT_START: len = 3;
      ACT_STOP:  len = 4;
      ACT_WRITE: len = 20;
      ACT_READ:  len = 19;
      default:   len = 1;
    endcase
    for (int k = 0; k < len; k++) begin
      if (k == 0) begin
        t.action = act;
        t.tx_byte = tx;
      end else begin
        t.action = (noise && $urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : ACT_NONE;
        t.tx_byte = 8'($urandom);
      end
      t.sda_in = 1'($urandom_range(0, 1));
      if (act == ACT_READ && k % 2 == 1 && k <= 15) t.sda_in = rd_byte[7 - (k - 1) / 2];
      if (act == ACT_WRITE && k == 18) t.sda_in = ack_bit;
      send_tick(t);
    end
  endtask

  task automatic random_ticks(int target);
    int nbytes;
    while (ticks_sent < target) begin
      if ($urandom_range(0, 99) < 80) begin
        run_command(ACT_START, 8'($urandom), 8'($urandom), 1'b0, $urandom_range(0, 1));
        nbytes = $urandom_range(1, 4);
        for (int b = 0; b < nbytes; b++) begin
          if ($urandom_range(0, 1) == 1)
            run_command(ACT_WRITE, 8'($urandom), 8'($urandom),
                        ($urandom_range(0, 3) == 0), $urandom_range(0, 1));
          else
            run_command(ACT_READ, 8'($urandom), 8'($urandom), 1'b0, $urandom_range(0, 1));
        end
        run_command(ACT_STOP, 8'($urandom), 8'($urandom), 1'b0, $urandom_range(0, 1));
        repeat ($urandom_range(0, 2))
          run_command(($urandom_range(0, 1) == 1) ? ACT_NONE : 3'($urandom_range(5, 7)),
                      8'($urandom), 8'($urandom), 1'b0, 1'b0);
      end else begin
        run_command(3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom),
                    1'($urandom_range(0, 1)), 1'b1);
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    snd_idle = 17;
    rcv_idle = 61;

    run_command(ACT_NONE, 8'hFF, 8'h00, 1'b1, 1'b0);
    run_command(ACT_STOP, 8'hFF, 8'h00, 1'b0, 1'b0);
    run_command(ACT_START, 8'hFF, 8'h00, 1'b0, 1'b0);
    run_command(ACT_WRITE, 8'hA5, 8'h00, 1'b0, 1'b0);
    run_command(ACT_WRITE, 8'hFF, 8'h00, 1'b1, 1'b1);
    run_command(ACT_WRITE, 8'h00, 8'h00, 1'b0, 1'b0);
    run_command(ACT_READ, 8'hFF, 8'hFF, 1'b0, 1'b1);
    run_command(ACT_READ, 8'h00, 8'h00, 1'b0, 1'b0);
    run_command(ACT_READ, 8'h5A, 8'h81, 1'b0, 1'b0);
    run_command(3'd5, 8'h00, 8'h00, 1'b0, 1'b0);
    run_command(3'd6, 8'hFF, 8'h00, 1'b0, 1'b0);
    run_command(3'd7, 8'h55, 8'h00, 1'b0, 1'b0);
    run_command(ACT_STOP, 8'h00, 8'h00, 1'b0, 1'b1);
    run_command(ACT_START, 8'h00, 8'h00, 1'b0, 1'b1);
    run_command(ACT_START, 8'h00, 8'h00, 1'b0, 1'b0);
    run_command(ACT_STOP, 8'hFF, 8'h00, 1'b0, 1'b0);

    random_ticks(TICK_TARGET / 3);
    snd_idle = 61;
    rcv_idle = 17;
    random_ticks(2 * TICK_TARGET / 3);
    snd_idle = 0;
    rcv_idle = 0;
    random_ticks(TICK_TARGET);
    in_valid <= 1'b0;

    while (sb.pending_levels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending_levels.size() != 0) begin
      $error("%0d expected result items never arrived", sb.pending_levels.size());
      sb.mismatches++;
    end

    $display("Drove %0d bus ticks and checked %0d result items.", ticks_sent, sb.checked);
    $display("Commands taken: %0d start, %0d stop, %0d write, %0d read.",
             sb.taken[ACT_START], sb.taken[ACT_STOP], sb.taken[ACT_WRITE], sb.taken[ACT_READ]);
    if (sb.mismatches == 0) begin
      $display("[i2c_master_byte_engine] OK");
    end else begin
      $display("[i2c_master_byte_engine] ERROR");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/core/i2cm_pkg.sv
rtl/core/i2cm_front.sv
rtl/core/i2cm_queue.sv
rtl/core/i2cm_back.sv
rtl/core/i2c_master_byte_engine.sv
sim/i2c_master_byte_engine_tb.sv
